FILE: design/nonuniform_simpson_integrator_defines.svh
// Assertion helpers for the integrator top module
`ifndef NONUNIFORM_SIMPSON_INTEGRATOR_DEFINES_SVH
`define NONUNIFORM_SIMPSON_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define NSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nsi: check failed");

// next-cycle implication
`define NSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nsi: check failed");

`endif

FILE: design/nsi_pkg.sv
package nsi_pkg;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } nsi_op_e;

  typedef struct packed {
    logic    start;
    nsi_op_e op;
  } nsi_req_t;

  typedef struct packed {
    logic [47:0] val;
    logic        sat;
  } nsi_clip_t;

  localparam logic [6:0]  MUL_STEPS = 7'd48;
  localparam logic [6:0]  DIV_STEPS = 7'd64;
  localparam logic [63:0] LIM48_U   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] MAG48_NEG = 64'h0000_8000_0000_0000;
  localparam logic [63:0] LIM62_U   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] LIM48     = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48     = 48'h8000_0000_0000;

  // signed 64-bit value clipped to 48 bits
  function automatic nsi_clip_t clip_s64(input logic signed [63:0] v);
    nsi_clip_t r;
    if (v > $signed(LIM48_U)) begin
      r.val = LIM48;
      r.sat = 1'b1;
    end else if (v < -$signed(MAG48_NEG)) begin
      r.val = MIN48;
      r.sat = 1'b1;
    end else begin
      r.val = v[47:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // sign applied to a magnitude, then clipped to 48 bits
  function automatic nsi_clip_t clip_mag48(input logic [63:0] mag, input logic neg);
    nsi_clip_t   r;
    logic [63:0] m_n;
    m_n = 64'(~mag + 64'd1);
    if (!neg) begin
      r.sat = (mag > LIM48_U);
      r.val = r.sat ? LIM48 : mag[47:0];
    end else begin
      r.sat = (mag > MAG48_NEG);
      r.val = r.sat ? MIN48 : m_n[47:0];
    end
    return r;
  endfunction

endpackage

FILE: design/nsi_muldiv.sv
module nsi_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsi_pkg::nsi_req_t req_i,
  input  logic [63:0]      opa_i,   // mul: multiplier in [47:0]; div: dividend
  input  logic [47:0]      opb_i,   // mul: multiplicand; div: divisor
  output logic             busy_o,
  output logic             done_o,
  output logic [95:0]      prod_o,
  output logic [63:0]      quo_o
);
  import nsi_pkg::*;

  logic        busy_q, done_q;
  nsi_op_e     op_q;
  logic [6:0]  cnt_q;
  logic [48:0] hi_q;
  logic [63:0] lo_q;
  logic [47:0] opb_q;

  logic [48:0] t_div;
  logic [49:0] add_x, add_y, sum;
  logic        ge;

  // one 50-bit adder serves both the add step and the trial subtract
  always_comb begin
    t_div = {hi_q[47:0], lo_q[63]};
    if (op_q == OP_MUL) begin
      add_x = {1'b0, hi_q};
      add_y = lo_q[0] ? {2'b00, opb_q} : 50'd0;
    end else begin
      add_x = {1'b0, t_div};
      add_y = ~{2'b00, opb_q};
    end
    sum = add_x + add_y + {49'd0, (op_q == OP_DIV)};
    ge  = ~sum[49];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == OP_MUL) ? MUL_STEPS : DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q  <= '0;
      lo_q  <= (req_i.op == OP_MUL) ? {16'd0, opa_i[47:0]} : opa_i;
      opb_q <= opb_i;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        hi_q <= sum[49:1];
        lo_q <= {lo_q[63:48], sum[0], lo_q[47:1]};
      end else begin
        hi_q <= ge ? sum[48:0] : t_div;
        lo_q <= {lo_q[62:0], ge};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = {hi_q[47:0], lo_q[47:0]};
  assign quo_o  = lo_q;

endmodule

FILE: design/nonuniform_simpson_integrator.sv
// Nonuniform Simpson integrator.
// Input stream: one (position, value) sample per request, tlast marks the last
// sample of a run. Output stream: one request per run carrying the 48-bit
// integral and two flags in tuser (zero-length interval, saturation).
// Every third sample of a run (and every second one after that) closes a pair
// of intervals and starts a computation on one shared shift-add / restoring
// divide unit: two 64-step divisions for h1/h0 and h0/h1, four 48-step
// multiplies and one 64-step division by six. New samples are accepted only
// while no pair is being computed. The result of a run is loaded into the
// output register in ST_FIN after the final pair is summed, once that register
// is free, or with the last sample itself when no pair is pending.
// The output register holds one result; while it is full and the receiver
// stalls, s_axis_tready stays low until it drains.
// Reset clears the run state, running sum, flags and the output valid.
`include "nonuniform_simpson_integrator_defines.svh"

module nonuniform_simpson_integrator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] sample_pos, [63:32] sample_value
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] integral
  output logic [1:0]  m_axis_tuser    // [0] zero_interval_fault, [1] saturated
);
  import nsi_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LAUNCH = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_ACCUM  = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  typedef enum logic [6:0] {
    STEP_DIVA = 7'b0000001,
    STEP_DIVB = 7'b0000010,
    STEP_MUL0 = 7'b0000100,
    STEP_MUL1 = 7'b0001000,
    STEP_MUL2 = 7'b0010000,
    STEP_MULS = 7'b0100000,
    STEP_DIV6 = 7'b1000000
  } step_e;

  localparam logic signed [49:0] TWO = 50'sd1 <<< (FRAC_BITS + 1);

  state_e             st_q, st_d;
  step_e              step_q, step_d;
  logic [1:0]         phase_q, phase_d;
  logic signed [31:0] px0_q, py0_q, px1_q, py1_q;
  logic signed [31:0] px0_d, py0_d, px1_d, py1_d;
  logic signed [31:0] ya_q, yb_q, yc_q, ya_d, yb_d, yc_d;
  logic signed [32:0] h0_q, h1_q, h0_d, h1_d;
  logic signed [47:0] a_q, b_q, a_d, b_d, t_q, t_d, sum_q, sum_d;
  logic signed [49:0] inner_q, inner_d;
  logic [63:0]        mag62_q, mag62_d;
  logic               neg_q, neg_d, fz_q, fz_d, fs_q, fs_d, last_q, last_d;
  logic               out_valid_q, out_valid_d, out_fz_q, out_fz_d, out_fs_q, out_fs_d;
  logic [47:0]        out_sum_q, out_sum_d;

  logic               s_acc, out_free, out_load, zero_hit;
  logic signed [31:0] in_pos, in_val;
  logic signed [32:0] h0_in, h1_in;
  logic signed [33:0] s_len;
  logic signed [49:0] c_src;
  logic signed [31:0] y_sel;
  nsi_clip_t          c_clip, inner_clip, r_clip, acc_clip;
  logic [31:0]        y_mag;
  logic [32:0]        h0_mag, h1_mag;
  logic [33:0]        s_mag;
  logic [47:0]        c_mag, inner_mag, q48;
  logic [95:0]        prod_sh;
  logic [63:0]        mag64;

  nsi_req_t           ureq;
  logic [63:0]        uopa;
  logic [47:0]        uopb;
  logic               unit_busy, unit_done;
  logic [95:0]        unit_prod;
  logic [63:0]        unit_quo;

  nsi_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .opa_i  (uopa),
    .opb_i  (uopb),
    .busy_o (unit_busy),
    .done_o (unit_done),
    .prod_o (unit_prod),
    .quo_o  (unit_quo)
  );

  assign in_pos   = s_axis_tdata[31:0];
  assign in_val   = s_axis_tdata[63:32];
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && out_free;
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  assign h0_in    = {px1_q[31], px1_q} - {px0_q[31], px0_q};
  assign h1_in    = {in_pos[31], in_pos} - {px1_q[31], px1_q};
  assign zero_hit = (h0_in == 33'sd0) || (h1_in == 33'sd0);

  // operand preparation for the current step
  always_comb begin
    unique case (step_q)
      STEP_MUL0: begin
        c_src = TWO - {{2{a_q[47]}}, a_q};
        y_sel = ya_q;
      end
      STEP_MUL1: begin
        c_src = TWO + {{2{a_q[47]}}, a_q} + {{2{b_q[47]}}, b_q};
        y_sel = yb_q;
      end
      STEP_MUL2: begin
        c_src = TWO - {{2{b_q[47]}}, b_q};
        y_sel = yc_q;
      end
      default: begin
        c_src = TWO;
        y_sel = ya_q;
      end
    endcase
    c_clip     = clip_s64({{14{c_src[49]}}, c_src});
    inner_clip = clip_s64({{14{inner_q[49]}}, inner_q});
    y_mag      = y_sel[31] ? 32'(-y_sel) : 32'(y_sel);
    c_mag      = c_clip.val[47] ? 48'(-c_clip.val) : c_clip.val;
    inner_mag  = inner_clip.val[47] ? 48'(-inner_clip.val) : inner_clip.val;
    h0_mag     = h0_q[32] ? 33'(-h0_q) : 33'(h0_q);
    h1_mag     = h1_q[32] ? 33'(-h1_q) : 33'(h1_q);
    s_len      = {h0_q[32], h0_q} + {h1_q[32], h1_q};
    s_mag      = s_len[33] ? 34'(-s_len) : 34'(s_len);
    prod_sh    = unit_prod >> FRAC_BITS;
    mag64      = (|prod_sh[95:64]) ? '1 : prod_sh[63:0];
    r_clip     = clip_mag48((step_q == STEP_DIV6) ? unit_quo : mag64, neg_q);
    q48        = (unit_quo > LIM48_U) ? LIM48 : unit_quo[47:0];
    acc_clip   = clip_s64(64'(sum_q) + 64'(t_q));
  end

  always_comb begin
    st_d    = st_q;
    step_d  = step_q;
    phase_d = phase_q;
    px0_d   = px0_q;
    py0_d   = py0_q;
    px1_d   = px1_q;
    py1_d   = py1_q;
    ya_d    = ya_q;
    yb_d    = yb_q;
    yc_d    = yc_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    a_d     = a_q;
    b_d     = b_q;
    t_d     = t_q;
    sum_d   = sum_q;
    inner_d = inner_q;
    mag62_d = mag62_q;
    neg_d   = neg_q;
    fz_d    = fz_q;
    fs_d    = fs_q;
    last_d  = last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_sum_d   = out_sum_q;
    out_fz_d    = out_fz_q;
    out_fs_d    = out_fs_q;
    out_load    = 1'b0;
    ureq.start  = 1'b0;
    ureq.op     = OP_MUL;
    uopa        = '0;
    uopb        = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          last_d = s_axis_tlast;
          unique case (phase_q)
            2'd0: begin
              px0_d   = in_pos;
              py0_d   = in_val;
              phase_d = 2'd1;
            end
            2'd1: begin
              px1_d   = in_pos;
              py1_d   = in_val;
              phase_d = 2'd2;
            end
            default: begin
              px0_d   = in_pos;
              py0_d   = in_val;
              phase_d = 2'd1;
              ya_d    = py0_q;
              yb_d    = py1_q;
              yc_d    = in_val;
              h0_d    = h0_in;
              h1_d    = h1_in;
              if (zero_hit) begin
                fz_d = 1'b1;
              end else begin
                st_d   = ST_LAUNCH;
                step_d = STEP_DIVA;
              end
            end
          endcase
          if (s_axis_tlast) begin
            phase_d = 2'd0;
            if (st_d == ST_IDLE) begin
              out_load    = 1'b1;
              out_valid_d = 1'b1;
              out_sum_d   = sum_q;
              out_fz_d    = fz_d;
              out_fs_d    = fs_q;
              sum_d       = '0;
              fz_d        = 1'b0;
              fs_d        = 1'b0;
            end
          end
        end
      end

      ST_LAUNCH: begin
        ureq.start = 1'b1;
        st_d       = ST_WAIT;
        unique case (step_q)
          STEP_DIVA: begin
            ureq.op = OP_DIV;
            uopa    = 64'(h1_mag) << FRAC_BITS;
            uopb    = 48'(h0_mag);
            neg_d   = h0_q[32] ^ h1_q[32];
          end
          STEP_DIVB: begin
            ureq.op = OP_DIV;
            uopa    = 64'(h0_mag) << FRAC_BITS;
            uopb    = 48'(h1_mag);
            neg_d   = h0_q[32] ^ h1_q[32];
          end
          STEP_MUL0, STEP_MUL1, STEP_MUL2: begin
            ureq.op = OP_MUL;
            uopa    = 64'(y_mag);
            uopb    = c_mag;
            neg_d   = y_sel[31] ^ c_clip.val[47];
            fs_d    = fs_q | c_clip.sat;
          end
          STEP_MULS: begin
            ureq.op = OP_MUL;
            uopa    = 64'(s_mag);
            uopb    = inner_mag;
            neg_d   = s_len[33] ^ inner_clip.val[47];
            fs_d    = fs_q | inner_clip.sat;
          end
          default: begin
            ureq.op = OP_DIV;
            uopa    = mag62_q;
            uopb    = 48'd6;
          end
        endcase
      end

      ST_WAIT: begin
        if (unit_done) begin
          st_d = ST_LAUNCH;
          unique case (step_q)
            STEP_DIVA: begin
              a_d    = neg_q ? 48'(-q48) : q48;
              fs_d   = fs_q | (unit_quo > LIM48_U);
              step_d = STEP_DIVB;
            end
            STEP_DIVB: begin
              b_d    = neg_q ? 48'(-q48) : q48;
              fs_d   = fs_q | (unit_quo > LIM48_U);
              step_d = STEP_MUL0;
            end
            STEP_MUL0: begin
              inner_d = {{2{r_clip.val[47]}}, r_clip.val};
              fs_d    = fs_q | r_clip.sat;
              step_d  = STEP_MUL1;
            end
            STEP_MUL1, STEP_MUL2: begin
              inner_d = inner_q + {{2{r_clip.val[47]}}, r_clip.val};
              fs_d    = fs_q | r_clip.sat;
              step_d  = (step_q == STEP_MUL1) ? STEP_MUL2 : STEP_MULS;
            end
            STEP_MULS: begin
              mag62_d = (|prod_sh[95:62]) ? LIM62_U : {2'b00, prod_sh[61:0]};
              fs_d    = fs_q | (|prod_sh[95:62]);
              step_d  = STEP_DIV6;
            end
            default: begin
              t_d  = r_clip.val;
              fs_d = fs_q | r_clip.sat;
              st_d = ST_ACCUM;
            end
          endcase
        end
      end

      ST_ACCUM: begin
        sum_d = acc_clip.val;
        fs_d  = fs_q | acc_clip.sat;
        st_d  = ST_FIN;
      end

      ST_FIN: begin
        if (!last_q) begin
          st_d = ST_IDLE;
        end else if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_sum_d   = sum_q;
          out_fz_d    = fz_q;
          out_fs_d    = fs_q;
          sum_d       = '0;
          fz_d        = 1'b0;
          fs_d        = 1'b0;
          st_d        = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= STEP_DIVA;
      phase_q     <= 2'd0;
      sum_q       <= '0;
      fz_q        <= 1'b0;
      fs_q        <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      px0_q       <= '0;
      py0_q       <= '0;
      px1_q       <= '0;
      py1_q       <= '0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      fz_q        <= fz_d;
      fs_q        <= fs_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      px0_q       <= px0_d;
      py0_q       <= py0_d;
      px1_q       <= px1_d;
      py1_q       <= py1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ya_q      <= ya_d;
    yb_q      <= yb_d;
    yc_q      <= yc_d;
    h0_q      <= h0_d;
    h1_q      <= h1_d;
    a_q       <= a_d;
    b_q       <= b_d;
    t_q       <= t_d;
    inner_q   <= inner_d;
    mag62_q   <= mag62_d;
    neg_q     <= neg_d;
    out_sum_q <= out_sum_d;
    out_fz_q  <= out_fz_d;
    out_fs_q  <= out_fs_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sum_q;
  assign m_axis_tuser  = {out_fs_q, out_fz_q};

  `NSI_ASSERT_NXT(a_last_clears_phase, s_acc && s_axis_tlast, phase_q == 2'd0)
  `NSI_ASSERT_IMP(a_done_in_wait, unit_done, st_q == ST_WAIT && !unit_busy)
  `NSI_ASSERT_NXT(a_pair_launches, s_acc && phase_q == 2'd2 && !zero_hit, st_q == ST_LAUNCH)
  `NSI_ASSERT_IMP(a_no_overrun, out_load, !out_valid_q || m_axis_tready)

endmodule
